/* hdl/rdc_pkg.sv */
// Package for the radix digit converter: widths shared by the converter,
// its divide step and its checker, and the radix limits and radix range
// test used by the converter. No dependencies.
package rdc_pkg;

   localparam int DIGIT_W    = 4;
   localparam int RADIX_W    = 4;
   localparam int REM_W      = DIGIT_W + 1;
   localparam int CHUNK_BITS = 8;

   localparam logic [RADIX_W-1:0] RADIX_MIN   = 4'd2;
   localparam logic [RADIX_W-1:0] RADIX_MAX   = 4'd10;
   localparam logic [RADIX_W-1:0] RADIX_RESET = 4'd10;
   localparam logic [DIGIT_W-1:0] DIGIT_MAX   = 4'd9;

   function automatic logic radix_ok(input logic [RADIX_W-1:0] radix);
      return radix inside {[RADIX_MIN:RADIX_MAX]};
   endfunction

endpackage

/* hdl/rdc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rdc_ram #(
   parameter int WIDTH = 4,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/rdc_div_step.sv */
// One long-division step of the converter: divides a chunk of quotient bits
// by the radix, carrying the partial remainder. Depends on rdc_pkg.
module rdc_div_step
   import rdc_pkg::*;
(
   input  logic [RADIX_W-1:0]    radix,
   input  logic [DIGIT_W-1:0]    rem_in,
   input  logic [CHUNK_BITS-1:0] data_in,
   output logic [CHUNK_BITS-1:0] quot_out,
   output logic [DIGIT_W-1:0]    rem_out
);

   always_comb begin
      logic [REM_W-1:0] part;
      logic [REM_W-1:0] divisor;
      part     = {1'b0, rem_in};
      divisor  = {1'b0, radix};
      quot_out = '0;
      for (int i = CHUNK_BITS - 1; i >= 0; i--) begin
         part = {part[DIGIT_W-1:0], data_in[i]};
         if (part >= divisor) begin
            quot_out[i] = 1'b1;
            part        = part - divisor;
         end
      end
      rem_out = part[DIGIT_W-1:0];
   end

endmodule

/* hdl/radix_digit_converter.sv */
// Each digit is divided out one 8-bit chunk at a time (VALUE_WIDTH/8 chunks
// rounded up, 8 for 64 bits), then the digit stack is popped through the READ
// and PUSH states, PUSH waiting while the result slot is full; a request is
// accepted in IDLE, one transaction at a time. The stack read is registered.
// Reset (synchronous): idle, radix 10, no result pending; stack not cleared.
// Top level of the radix digit converter; depends on rdc_pkg, rdc_div_step, rdc_ram.
module radix_digit_converter
   import rdc_pkg::*;
#(
   parameter int VALUE_WIDTH = 64,
   parameter int MAX_DIGITS  = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [RADIX_W-1:0] csr_radix,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [63:0]        req_value,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [DIGIT_W-1:0] rsp_digit,
   output logic               rsp_last,
   output logic               rsp_bad_radix
);

   localparam int CHUNKS = (VALUE_WIDTH + CHUNK_BITS - 1) / CHUNK_BITS;
   localparam int PAD_W  = CHUNKS * CHUNK_BITS;
   localparam int CHW    = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
   localparam int CNT_W  = $clog2(MAX_DIGITS + 1);
   localparam int AW     = $clog2(MAX_DIGITS);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_READ,
      ST_PUSH,
      ST_ERROR
   } state_type;

   state_type          state_ff, state_in;
   logic [RADIX_W-1:0] radix_ff, radix_in;
   logic [PAD_W-1:0]   quot_ff, quot_in;
   logic [DIGIT_W-1:0] rem_ff, rem_in;
   logic [CHW-1:0]     chunk_ff, chunk_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [DIGIT_W-1:0] rsp_digit_ff, rsp_digit_in;
   logic               rsp_last_ff, rsp_last_in;
   logic               rsp_bad_ff, rsp_bad_in;

   logic [CHUNK_BITS-1:0] div_quot;
   logic [DIGIT_W-1:0]    div_rem;
   logic [PAD_W-1:0]      quot_next;
   logic [CNT_W-1:0]      cnt_dec;
   logic                  stack_wr;
   logic [DIGIT_W-1:0]    stack_rd_data;
   logic                  slot_free;

   rdc_div_step u_div_step (
      .radix    (radix_ff),
      .rem_in   (rem_ff),
      .data_in  (quot_ff[PAD_W-1 -: CHUNK_BITS]),
      .quot_out (div_quot),
      .rem_out  (div_rem)
   );

   rdc_ram #(
      .WIDTH (DIGIT_W),
      .DEPTH (MAX_DIGITS)
   ) u_stack (
      .clock   (clock),
      .wr_en   (stack_wr),
      .wr_addr (cnt_ff[AW-1:0]),
      .wr_data (div_rem),
      .rd_addr (cnt_dec[AW-1:0]),
      .rd_data (stack_rd_data)
   );

   assign quot_next = PAD_W'({quot_ff, div_quot});
   assign cnt_dec   = cnt_ff - CNT_W'(1);
   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      radix_in     = radix_ff;
      quot_in      = quot_ff;
      rem_in       = rem_ff;
      chunk_in     = chunk_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_digit_in = rsp_digit_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_bad_in   = rsp_bad_ff;
      stack_wr     = 1'b0;

      if (csr_valid) begin
         radix_in = csr_radix;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (radix_ok(radix_ff)) begin
                  quot_in  = PAD_W'(req_value[VALUE_WIDTH-1:0]);
                  rem_in   = '0;
                  chunk_in = '0;
                  cnt_in   = '0;
                  state_in = ST_DIVIDE;
               end else begin
                  state_in = ST_ERROR;
               end
            end
         end
         ST_DIVIDE: begin
            quot_in = quot_next;
            rem_in  = div_rem;
            if (chunk_ff == CHW'(CHUNKS - 1)) begin
               chunk_in = '0;
               rem_in   = '0;
               stack_wr = 1'b1;
               cnt_in   = cnt_ff + CNT_W'(1);
               if (quot_next == '0 || cnt_ff == CNT_W'(MAX_DIGITS - 1)) begin
                  state_in = ST_READ;
               end
            end else begin
               chunk_in = chunk_ff + CHW'(1);
            end
         end
         ST_READ: begin
            state_in = ST_PUSH;
         end
         ST_PUSH: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_digit_in = stack_rd_data;
               rsp_last_in  = (cnt_ff == CNT_W'(1));
               rsp_bad_in   = 1'b0;
               cnt_in       = cnt_dec;
               state_in     = (cnt_ff == CNT_W'(1)) ? ST_IDLE : ST_READ;
            end
         end
         ST_ERROR: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_digit_in = '0;
               rsp_last_in  = 1'b1;
               rsp_bad_in   = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         radix_ff     <= RADIX_RESET;
         chunk_ff     <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         radix_ff     <= radix_in;
         chunk_ff     <= chunk_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      quot_ff      <= quot_in;
      rem_ff       <= rem_in;
      rsp_digit_ff <= rsp_digit_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_bad_ff   <= rsp_bad_in;
   end

   assign csr_ready     = 1'b1;
   assign req_ready     = (state_ff == ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_digit     = rsp_digit_ff;
   assign rsp_last      = rsp_last_ff;
   assign rsp_bad_radix = rsp_bad_ff;

endmodule

/* hdl/rdc_checker.sv */
// Port-level checks for the radix digit converter, bound to its top level.
// Depends on rdc_pkg and radix_digit_converter.
module rdc_checker
   import rdc_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               csr_valid,
   input logic               csr_ready,
   input logic [RADIX_W-1:0] csr_radix,
   input logic               req_valid,
   input logic               req_ready,
   input logic [63:0]        req_value,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [DIGIT_W-1:0] rsp_digit,
   input logic               rsp_last,
   input logic               rsp_bad_radix
);

   // hold a stalled result transaction
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_digit) && $stable(rsp_last)
         && $stable(rsp_bad_radix))
      else $error("stalled result transaction changed");

   a_bad_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bad_radix |-> rsp_last && rsp_digit == '0)
      else $error("bad radix result is not a single zero digit");

   a_digit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_bad_radix |-> rsp_digit <= DIGIT_MAX)
      else $error("digit out of range");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while a conversion is running");

endmodule

bind radix_digit_converter rdc_checker u_rdc_checker (.*);
